FILE: rtl/sli_pkg.sv
// Package with the transaction types and command codes of the sorted list intersection block.
`timescale 1ns / 1ps

package sli_pkg;

  localparam int unsigned ValueW = 32;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdProbe = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ValueW-1:0] value;
    logic              last;
  } sli_in_t;

  typedef struct packed {
    logic [ValueW-1:0] value_res;
    logic              found;
    logic              is_last;
    logic              overflowed;
  } sli_out_t;

endpackage

FILE: rtl/sli_mem.sv
// Simple dual-port synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps

module sli_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sorted_list_intersection.sv
// Top level of the sorted list intersection block: merge controller around the list memory.
`timescale 1ns / 1ps

// Input transactions carry cmd, value and last. A load (cmd 0) appends its value to the
// stored first list; the first load after a completed run starts a new list. Loads beyond
// MAX_LIST_LEN entries are dropped and raise the overflowed flag of later results.
// A probe (cmd 1) walks the merge pointer forward through the memory, one stored entry per
// cycle, and produces exactly one output transaction with the echoed value, found, is_last
// and overflowed. A probe with last set ends the run and rewinds the pointer.
// A load completes on acceptance. A probe reads the entry at the pointer from idle, walks the
// stored entries in StCompare and registers its result from StDone, after which the block
// returns to idle; no new transaction is accepted before then. A probe with no stored entry
// ahead of the pointer skips StCompare. The single read port of the list memory paces the
// walk.
// The output register lets a new transaction be accepted while a result waits; a finished
// probe holds in its last step while the receiver stalls with a result still pending.
// Reset empties the stored list, clears the flags and arms the start of a new list. The
// memory contents are not cleared, and no clearing pass is needed.
module sorted_list_intersection #(
  parameter int unsigned MAX_LIST_LEN = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sli_pkg::sli_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sli_pkg::sli_out_t out_data_o
);

  localparam int unsigned AddrW = (MAX_LIST_LEN > 1) ? $clog2(MAX_LIST_LEN) : 1;
  localparam int unsigned CntW  = $clog2(MAX_LIST_LEN + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_LIST_LEN);

  typedef enum logic [1:0] {
    StIdle,
    StCompare,
    StDone
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               ptr_q, ptr_d;
  logic [CntW-1:0]               count_q, count_d;
  logic                          start_q, start_d;
  logic                          ovf_q, ovf_d;
  logic [sli_pkg::ValueW-1:0]    val_q, val_d;
  logic                          last_q, last_d;
  logic                          hit_q, hit_d;
  logic                          out_valid_q, out_valid_d;
  sli_pkg::sli_out_t             out_data_q, out_data_d;

  logic                          mem_we;
  logic [AddrW-1:0]              mem_waddr;
  logic                          mem_re;
  logic [AddrW-1:0]              mem_raddr;
  logic [sli_pkg::ValueW-1:0]    mem_rdata;
  logic [CntW-1:0]               ptr_inc;
  logic [CntW-1:0]               base_cnt;

  sli_mem #(
    .Depth(MAX_LIST_LEN),
    .Width(sli_pkg::ValueW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_data_i.value),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign ptr_inc  = ptr_q + 1'b1;
  assign base_cnt = start_q ? '0 : count_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    start_d     = start_q;
    ovf_d       = ovf_q;
    val_d       = val_q;
    last_d      = last_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = base_cnt[AddrW-1:0];
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[AddrW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == sli_pkg::CmdLoad) begin
            if (start_q) begin
              ptr_d   = '0;
              ovf_d   = 1'b0;
              start_d = 1'b0;
            end
            if (base_cnt < MaxCount) begin
              mem_we  = 1'b1;
              count_d = base_cnt + 1'b1;
            end else begin
              count_d = base_cnt;
              ovf_d   = 1'b1;
            end
          end else begin
            val_d  = in_data_i.value;
            last_d = in_data_i.last;
            hit_d  = 1'b0;
            if (ptr_q < count_q) begin
              mem_re  = 1'b1;
              state_d = StCompare;
            end else begin
              state_d = StDone;
            end
          end
        end
      end
      StCompare: begin
        if (mem_rdata < val_q) begin
          ptr_d = ptr_inc;
          if (ptr_inc < count_q) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_inc[AddrW-1:0];
          end else begin
            state_d = StDone;
          end
        end else if (mem_rdata == val_q) begin
          hit_d   = 1'b1;
          ptr_d   = ptr_inc;
          state_d = StDone;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_data_d.value_res  = val_q;
          out_data_d.found      = hit_q;
          out_data_d.is_last    = last_q;
          out_data_d.overflowed = ovf_q;
          if (last_q) begin
            start_d = 1'b1;
            ptr_d   = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      count_q     <= '0;
      start_q     <= 1'b1;
      ovf_q       <= 1'b0;
      val_q       <= '0;
      last_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      start_q     <= start_d;
      ovf_q       <= ovf_d;
      val_q       <= val_d;
      last_q      <= last_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/sli_checker.sv
// Port-level checker for the sorted list intersection block and its bind statement.
`timescale 1ns / 1ps

module sli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input sli_pkg::sli_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sli_pkg::sli_out_t out_data_o
);

  // A stalled result stays in place until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed or dropped.");

  // A probe keeps the block busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd == sli_pkg::CmdProbe) |=> !in_ready_o)
    else $error("Input accepted right after a probe.");

  // A load never creates a result on its own.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && in_ready_o && (in_data_i.cmd == sli_pkg::CmdLoad)
    |=> !out_valid_o)
    else $error("Result appeared after a load.");

  // A new result is only registered at the end of a probe, while input is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared while the block was idle.");

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

FILE: tb/sv/sorted_list_intersection_tb.sv
// Self-checking testbench: directed and random list transactions against a merge predictor.
`timescale 1ns / 1ps

module sorted_list_intersection_tb;

  localparam int unsigned ListDepth = 1024;
  localparam realtime StopAfter = 5_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  sli_pkg::sli_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  sli_pkg::sli_out_t out_data_o;

  class intersect_scoreboard;
    logic [sli_pkg::ValueW-1:0] list_mem [ListDepth];
    int unsigned                stored_cnt;
    int unsigned                merge_ptr;
    bit                         fresh_list;
    bit                         dropped;
    sli_pkg::sli_out_t          probe_results_q [$];
    int unsigned                errors;

    function new();
      stored_cnt = 0;
      merge_ptr  = 0;
      fresh_list = 1'b1;
      dropped    = 1'b0;
      errors     = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function int unsigned pending();
      return probe_results_q.size();
    endfunction

    function void note_input(sli_pkg::sli_in_t item);
      sli_pkg::sli_out_t res;
      if (item.cmd == sli_pkg::CmdLoad) begin
        if (fresh_list) begin
          stored_cnt = 0;
          merge_ptr  = 0;
          dropped    = 1'b0;
          fresh_list = 1'b0;
        end
        if (stored_cnt < ListDepth) begin
          list_mem[stored_cnt] = item.value;
          stored_cnt++;
        end else begin
          dropped = 1'b1;
        end
        return;
      end
      while (merge_ptr < stored_cnt && list_mem[merge_ptr] < item.value) merge_ptr++;
      res.value_res  = item.value;
      res.found      = (merge_ptr < stored_cnt) && (list_mem[merge_ptr] == item.value);
      res.is_last    = item.last;
      res.overflowed = dropped;
      if (res.found) merge_ptr++;
      if (item.last) begin
        fresh_list = 1'b1;
        merge_ptr  = 0;
      end
      probe_results_q = {probe_results_q, res};
    endfunction

    function void check_result(sli_pkg::sli_out_t got);
      sli_pkg::sli_out_t exp;
      if (probe_results_q.size() == 0) begin
        report($sformatf("result %h with no probe outstanding", got));
        return;
      end
      exp = probe_results_q.pop_front();
      if (got.value_res !== exp.value_res)
        report($sformatf("value_res expected %h actual %h", exp.value_res, got.value_res));
      if (got.found !== exp.found)
        report($sformatf("found for %h expected %b actual %b", exp.value_res, exp.found,
                         got.found));
      if (got.is_last !== exp.is_last)
        report($sformatf("is_last for %h expected %b actual %b", exp.value_res, exp.is_last,
                         got.is_last));
      if (got.overflowed !== exp.overflowed)
        report($sformatf("overflowed for %h expected %b actual %b", exp.value_res,
                         exp.overflowed, got.overflowed));
    endfunction

    function void flag_leftovers();
      while (probe_results_q.size() != 0) begin
        report($sformatf("result %h never arrived", probe_results_q[0]));
        void'(probe_results_q.pop_front());
      end
    endfunction
  endclass

  intersect_scoreboard sb = new();
  int unsigned         items_sent = 0;
  bit                  steady_src = 1'b0;
  bit                  steady_sink = 1'b0;

  sorted_list_intersection #(
    .MAX_LIST_LEN(ListDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic sli_pkg::sli_in_t make_item(logic cmd, logic [sli_pkg::ValueW-1:0] value,
                                                 logic last);
    sli_pkg::sli_in_t item;
    item.cmd   = cmd;
    item.value = value;
    item.last  = last;
    return item;
  endfunction

  task automatic send_item(sli_pkg::sli_in_t item);
    int unsigned gap;
    gap = draw_gap(steady_src);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_directed();
    send_item(make_item(sli_pkg::CmdProbe, 32'h0000_0000, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(sli_pkg::CmdLoad, 32'h0000_0000, 1'b0));
    send_item(make_item(sli_pkg::CmdLoad, 32'd5, 1'b0));
    send_item(make_item(sli_pkg::CmdLoad, 32'd5, 1'b0));
    send_item(make_item(sli_pkg::CmdLoad, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(sli_pkg::CmdProbe, 32'd5, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'd5, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'd3, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'd5, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(sli_pkg::CmdProbe, 32'h0000_0000, 1'b1));
    send_item(make_item(sli_pkg::CmdLoad, 32'd7, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'd1, 1'b0));
    send_item(make_item(sli_pkg::CmdLoad, 32'd9, 1'b0));
    send_item(make_item(sli_pkg::CmdProbe, 32'd9, 1'b1));
  endtask

  task automatic send_random_round();
    int unsigned                kind;
    int unsigned                n_load;
    int unsigned                n_probe;
    int unsigned                cut;
    bit                         broken;
    bit                         drop_last;
    bit                         mid_load;
    bit                         lst;
    logic [sli_pkg::ValueW-1:0] base;
    logic [sli_pkg::ValueW-1:0] acc;
    logic [sli_pkg::ValueW-1:0] val;
    kind       = $urandom_range(0, 99);
    steady_src = ($urandom_range(0, 4) == 0);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) begin
        send_item(make_item(($urandom_range(0, 1) == 1) ? sli_pkg::CmdProbe : sli_pkg::CmdLoad,
                            $urandom, ($urandom_range(0, 1) == 1)));
      end
      return;
    end
    case ($urandom_range(0, 9))
      0: base = '0;
      1: base = 32'hFFFF_FFFF - 32'd40;
      default: begin
        base = $urandom;
        if (base > 32'hFFFF_FFC0) base = 32'hFFFF_FFC0;
      end
    endcase
    broken = (kind < 22);
    n_load = $urandom_range(0, 10);
    acc    = base;
    for (int unsigned i = 0; i < n_load; i++) begin
      acc += $urandom_range(0, 3);
      if (i == n_load - 1) lst = ($urandom_range(0, 1) == 1);
      else lst = ($urandom_range(0, 9) == 0);
      send_item(make_item(sli_pkg::CmdLoad, acc, lst));
    end
    n_probe   = $urandom_range(1, 10);
    mid_load  = ($urandom_range(0, 6) == 0);
    cut       = $urandom_range(0, n_probe - 1);
    drop_last = broken && ($urandom_range(0, 1) == 1);
    acc       = base;
    for (int unsigned i = 0; i < n_probe; i++) begin
      if (mid_load && i == cut) begin
        send_item(make_item(sli_pkg::CmdLoad, base + $urandom_range(0, 40), 1'b0));
      end
      if (broken && !drop_last) begin
        val = base + $urandom_range(0, 40);
      end else begin
        acc += $urandom_range(0, 3);
        val = acc;
      end
      lst = (i == n_probe - 1) && !drop_last;
      send_item(make_item(sli_pkg::CmdProbe, val, lst));
    end
    if ($urandom_range(0, 9) == 0) drain_results();
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) steady_sink = ~steady_sink;
      stall = draw_gap(steady_sink);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #(StopAfter);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_directed();
    drain_results();
    while (items_sent < 490) send_random_round();
    drain_results();
    repeat (40) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
